>>> sv/simplex_noise_2d_assert.svh
// Assertion macros for the simplex noise RTL
`ifndef SIMPLEX_NOISE_2D_ASSERT_SVH
`define SIMPLEX_NOISE_2D_ASSERT_SVH
// same-cycle implication, sampled on aclk, off during reset
`define SNX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on aclk, off during reset
`define SNX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/snx_pkg.sv
// Shared types, constants and helper functions for the simplex noise pipeline
package snx_pkg;

    localparam int DEF_TABLE_SIZE      = 256;
    localparam int DEF_COORD_FRAC_BITS = 16;

    localparam int COORD_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int VAL_W    = 9;
    localparam int GRAD_W   = 4;
    localparam int NOISE_W  = 16;
    localparam int TERM_W   = 30;
    localparam int U_W      = 30;

    // skew and unskew factors, unsigned Q0.32
    localparam longint SKEW_Q32   = 1572067139;
    localparam longint UNSKEW_Q32 = 907633386;
    localparam int     NOISE_SCALE = 70;

    // pipeline positions of each section, counted from the input register
    localparam int GEOM_LAT   = 7;
    localparam int PERM_POS   = GEOM_LAT;
    localparam int GRAD_POS   = GEOM_LAT + 2;
    localparam int CORNER_END = GEOM_LAT + 5;
    localparam int PIPE_DEPTH = CORNER_END + 2;

    // control word that travels beside each request
    typedef struct packed {
        logic               vld;
        logic               eval;
        logic [INDEX_W-1:0] idx;
        logic [VAL_W-1:0]   val;
    } ctl_t;

    // table write request
    typedef struct packed {
        logic               wr;
        logic [INDEX_W-1:0] idx;
        logic [VAL_W-1:0]   val;
    } tbl_wr_t;

    // value modulo 12 by reciprocal multiply, exact for 9-bit values
    function automatic logic [GRAD_W-1:0] grad_mod(input logic [VAL_W-1:0] v);
        logic [17:0] prod;
        logic [5:0]  q;
        logic [9:0]  qx12;
        prod = 18'(v) * 18'd171;
        q    = prod[16:11];
        qx12 = 10'(q) * 10'd12;
        return GRAD_W'(10'(v) - qx12);
    endfunction

    // x component of the gradient vector; codes past eleven act as plus one
    function automatic logic signed [1:0] grad_x(input logic [GRAD_W-1:0] g);
        logic signed [1:0] r;
        unique case (g)
            4'd0, 4'd2, 4'd4, 4'd6: r = 2'sd1;
            4'd1, 4'd3, 4'd5, 4'd7: r = -2'sd1;
            4'd8, 4'd9, 4'd10, 4'd11: r = 2'sd0;
            default: r = 2'sd1;
        endcase
        return r;
    endfunction

    // y component of the gradient vector
    function automatic logic signed [1:0] grad_y(input logic [GRAD_W-1:0] g);
        logic signed [1:0] r;
        unique case (g)
            4'd0, 4'd1, 4'd8, 4'd10: r = 2'sd1;
            4'd2, 4'd3, 4'd9, 4'd11: r = -2'sd1;
            4'd4, 4'd5, 4'd6, 4'd7:  r = 2'sd0;
            default: r = 2'sd1;
        endcase
        return r;
    endfunction

endpackage

>>> sv/snx_geom.sv
// Skew, cell search, unskew and corner offsets (seven register stages)
module snx_geom import snx_pkg::*; #(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int TB              = 8
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [COORD_W-1:0]         x_coord,
    input  logic signed [COORD_W-1:0]         y_coord,
    output logic [TB-1:0]                     ii,
    output logic [TB-1:0]                     jj,
    output logic                              step,
    output logic signed [COORD_FRAC_BITS+2:0] dx [3],
    output logic signed [COORD_FRAC_BITS+2:0] dy [3]
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int XYW = COORD_W + 1;
    localparam int SPW = 2 * XYW;
    localparam int XSW = COORD_W + 2;
    localparam int IW  = XSW - F;
    localparam int IJW = IW + 1;
    localparam int BXW = XSW + 1;
    localparam int PW  = IJW + 32;
    localparam int TW  = BXW + 1;
    localparam int OW  = F + 3;
    localparam logic signed [OW-1:0] ONE   = OW'(2 ** F);
    localparam logic signed [OW-1:0] G2F   = OW'(UNSKEW_Q32 >>> (32 - F));
    localparam logic signed [OW-1:0] G2X2F = OW'((2 * UNSKEW_Q32) >>> (32 - F));

    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [XYW-1:0]     xy1_reg, s2_reg, s3_reg;
    logic signed [SPW-1:0]     skew_prod;
    logic signed [XSW-1:0]     xs_next, ys_next;
    logic signed [IW-1:0]      i3_reg, j3_reg;
    logic [F-1:0]              fx3_reg, fy3_reg;
    logic signed [IJW-1:0]     ij4_reg;
    logic signed [BXW-1:0]     bx4_reg, by4_reg, bx5_reg, by5_reg;
    logic [TB-1:0]             ii4_reg, jj4_reg, ii5_reg, jj5_reg, ii6_reg, jj6_reg;
    logic [TB-1:0]             ii7_reg, jj7_reg;
    logic signed [PW-1:0]      unskew_prod;
    logic signed [TW-1:0]      t5_reg, x0_next, y0_next;
    logic signed [OW-1:0]      x06_reg, y06_reg;
    logic                      step_next, step7_reg;
    logic signed [OW-1:0]      dx_next [3];
    logic signed [OW-1:0]      dy_next [3];
    logic signed [OW-1:0]      dx7_reg [3];
    logic signed [OW-1:0]      dy7_reg [3];

    // skew product, cell split and corner offsets
    assign skew_prod   = SPW'(xy1_reg) * SPW'(SKEW_Q32);
    assign xs_next     = XSW'(x2_reg) + XSW'(s2_reg);
    assign ys_next     = XSW'(y2_reg) + XSW'(s2_reg);
    assign unskew_prod = PW'(ij4_reg) * PW'(UNSKEW_Q32);
    assign x0_next     = TW'(bx5_reg) + t5_reg;
    assign y0_next     = TW'(by5_reg) + t5_reg;

    always_comb begin
        step_next  = (x06_reg > y06_reg);
        dx_next[0] = x06_reg;
        dy_next[0] = y06_reg;
        dx_next[1] = x06_reg - (step_next ? ONE : '0) + G2F;
        dy_next[1] = y06_reg - (step_next ? '0 : ONE) + G2F;
        dx_next[2] = x06_reg - ONE + G2X2F;
        dy_next[2] = y06_reg - ONE + G2X2F;
    end

    // advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= x_coord;
            y1_reg    <= y_coord;
            xy1_reg   <= XYW'(x_coord) + XYW'(y_coord);
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            s2_reg    <= skew_prod[SPW-2:32];
            i3_reg    <= xs_next[XSW-1:F];
            j3_reg    <= ys_next[XSW-1:F];
            fx3_reg   <= xs_next[F-1:0];
            fy3_reg   <= ys_next[F-1:0];
            s3_reg    <= s2_reg;
            ij4_reg   <= IJW'(i3_reg) + IJW'(j3_reg);
            bx4_reg   <= BXW'($signed({1'b0, fx3_reg})) - BXW'(s3_reg);
            by4_reg   <= BXW'($signed({1'b0, fy3_reg})) - BXW'(s3_reg);
            ii4_reg   <= TB'(i3_reg);
            jj4_reg   <= TB'(j3_reg);
            t5_reg    <= TW'(unskew_prod >>> (32 - F));
            bx5_reg   <= bx4_reg;
            by5_reg   <= by4_reg;
            ii5_reg   <= ii4_reg;
            jj5_reg   <= jj4_reg;
            x06_reg   <= OW'(x0_next);
            y06_reg   <= OW'(y0_next);
            ii6_reg   <= ii5_reg;
            jj6_reg   <= jj5_reg;
            step7_reg <= step_next;
            ii7_reg   <= ii6_reg;
            jj7_reg   <= jj6_reg;
            dx7_reg   <= dx_next;
            dy7_reg   <= dy_next;
        end
    end

    assign ii   = ii7_reg;
    assign jj   = jj7_reg;
    assign step = step7_reg;
    assign dx   = dx7_reg;
    assign dy   = dy7_reg;

endmodule

>>> sv/snx_hash.sv
// Permutation and gradient index tables with three-stage corner hashing
module snx_hash import snx_pkg::*; #(
    parameter int TB = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  tbl_wr_t           perm_wr,
    input  tbl_wr_t           grad_wr,
    input  logic [TB-1:0]     ii,
    input  logic [TB-1:0]     jj,
    input  logic              step,
    output logic [GRAD_W-1:0] g [3]
);

    localparam int DEPTH = 2 ** TB;

    logic [VAL_W-1:0]  perm_mem   [DEPTH];
    logic [GRAD_W-1:0] grad_a_mem [DEPTH];
    logic [GRAD_W-1:0] grad_b_mem [DEPTH];

    logic [TB-1:0]     jj_inc;
    logic [VAL_W-1:0]  p0_reg, p1_reg;
    logic [TB-1:0]     ii1_reg;
    logic              step1_reg;
    logic [TB-1:0]     a0_next, a1_next, a2_next;
    logic [TB-1:0]     a0_reg, a1_reg, a2_reg;
    logic [GRAD_W-1:0] g0_reg, g1_reg, g2_reg;

    assign jj_inc = jj + TB'(1);

    // write a permutation entry, read both candidate rows
    always_ff @(posedge aclk) begin
        if (en) begin
            if (perm_wr.wr) begin
                perm_mem[TB'(perm_wr.idx)] <= perm_wr.val;
            end
            p0_reg    <= perm_mem[jj];
            p1_reg    <= perm_mem[jj_inc];
            ii1_reg   <= ii;
            step1_reg <= step;
        end
    end

    // form the three gradient table addresses
    always_comb begin
        a0_next = ii1_reg + TB'(p0_reg);
        a1_next = ii1_reg + TB'(step1_reg) + TB'(step1_reg ? p0_reg : p1_reg);
        a2_next = ii1_reg + TB'(1) + TB'(p1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            a2_reg <= a2_next;
        end
    end

    // write both gradient copies, read three corners
    always_ff @(posedge aclk) begin
        if (en) begin
            if (grad_wr.wr) begin
                grad_a_mem[TB'(grad_wr.idx)] <= grad_mod(grad_wr.val);
                grad_b_mem[TB'(grad_wr.idx)] <= grad_mod(grad_wr.val);
            end
            g0_reg <= grad_a_mem[a0_reg];
            g1_reg <= grad_a_mem[a1_reg];
            g2_reg <= grad_b_mem[a2_reg];
        end
    end

    assign g[0] = g0_reg;
    assign g[1] = g1_reg;
    assign g[2] = g2_reg;

endmodule

>>> sv/snx_corner.sv
// One corner contribution: falloff to the fourth power times gradient dot product
module snx_corner import snx_pkg::*; #(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [COORD_FRAC_BITS+2:0] dx,
    input  logic signed [COORD_FRAC_BITS+2:0] dy,
    input  logic [GRAD_W-1:0]                 g,
    output logic signed [TERM_W-1:0]          term
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int OW  = F + 3;
    localparam int SQW = 2 * OW + 2;
    localparam int QW  = SQW + 30;
    localparam int DW  = OW + 1;
    localparam int DQW = 35;
    localparam int MW  = 64;
    localparam logic signed [SQW-1:0] HALF = SQW'(2) ** (2 * F - 1);

    logic signed [SQW-1:0] base_next;
    logic signed [QW-1:0]  base_q30;
    logic [U_W-1:0]        u1_reg;
    logic [2*U_W-1:0]      u_sq, u2_sq;
    logic [28:0]           u2_reg;
    logic [26:0]           u4_3_reg, u4_4_reg;
    logic                  pos1_reg, pos2_reg, pos3_reg, pos4_reg;
    logic signed [OW-1:0]  dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [DW-1:0]  tx, ty, d_next;
    logic signed [DQW-1:0] dq4_reg;
    logic signed [MW-1:0]  prod;
    logic signed [TERM_W-1:0] term5_reg;

    // falloff base 0.5 - dx^2 - dy^2, floored to Q.30
    assign base_next = HALF - SQW'(dx) * SQW'(dx) - SQW'(dy) * SQW'(dy);
    assign base_q30  = (QW'(base_next) <<< 30) >>> (2 * F);
    assign u_sq      = (2 * U_W)'(u1_reg) * (2 * U_W)'(u1_reg);
    assign u2_sq     = (2 * U_W)'(u2_reg) * (2 * U_W)'(u2_reg);

    // dot product with the gradient, x and y only
    always_comb begin
        unique case (grad_x(g))
            2'sd1:   tx = DW'(dx3_reg);
            -2'sd1:  tx = -DW'(dx3_reg);
            default: tx = '0;
        endcase
        unique case (grad_y(g))
            2'sd1:   ty = DW'(dy3_reg);
            -2'sd1:  ty = -DW'(dy3_reg);
            default: ty = '0;
        endcase
        d_next = tx + ty;
    end

    assign prod = MW'($signed({1'b0, u4_4_reg})) * MW'(dq4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg    <= base_q30[U_W-1:0];
            pos1_reg  <= !base_next[SQW-1];
            dx1_reg   <= dx;
            dy1_reg   <= dy;
            u2_reg    <= u_sq[58:30];
            pos2_reg  <= pos1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            u4_3_reg  <= u2_sq[56:30];
            pos3_reg  <= pos2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            dq4_reg   <= DQW'(d_next) <<< (30 - F);
            u4_4_reg  <= u4_3_reg;
            pos4_reg  <= pos3_reg;
            term5_reg <= pos4_reg ? TERM_W'(prod >>> 30) : '0;
        end
    end

    assign term = term5_reg;

endmodule

>>> sv/simplex_noise_2d.sv
// An accepted evaluation reaches m_tvalid via the control pipe and the output register.
// Throughput: one request per cycle; loads and evaluations share the same 14-stage pipe.
// The whole pipe holds only while a finished result waits and the last stage has another.
// Table lookups use one two-read permutation RAM and two gradient RAM copies.
// Reset clears valid bits only; table contents are undefined until loaded.
// TABLE_SIZE must be a power of two; indices wrap by keeping low bits.
`include "simplex_noise_2d_assert.svh"
module simplex_noise_2d import snx_pkg::*; #(
    parameter int TABLE_SIZE      = DEF_TABLE_SIZE,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // table_index[7:0], table_value[16:8], x_coord[48:17],
                                  // y_coord[80:49], zero pad[87:81]
    input  logic [0:0]  s_tuser,  // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // noise_value[15:0]
);

    localparam int TB = $clog2(TABLE_SIZE);
    localparam int OW = COORD_FRAC_BITS + 3;
    localparam int SUMW = TERM_W + 2;
    localparam int SCW  = SUMW + 8;
    localparam logic signed [SCW-1:0] ROUND_HALF = SCW'(2 ** 14);
    localparam logic signed [SCW-1:0] SAT_HI = SCW'(32767);
    localparam logic signed [SCW-1:0] SAT_LO = -SCW'(32768);

    ctl_t                   ctl_reg [1:PIPE_DEPTH];
    logic                   en;
    logic                   last_eval, last_load;
    tbl_wr_t                perm_wr, grad_wr;
    logic [TB-1:0]          ii, jj;
    logic                   step;
    logic signed [OW-1:0]   dx [3];
    logic signed [OW-1:0]   dy [3];
    logic [GRAD_W-1:0]      g [3];
    logic signed [TERM_W-1:0] term [3];
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SCW-1:0]  scaled;
    logic [NOISE_W-1:0]     noise_next, noise_reg;
    logic                   out_vld_next, out_vld_reg;
    logic [NOISE_W-1:0]     out_noise_reg;

    // kind of request in the last stage
    assign last_eval = ctl_reg[PIPE_DEPTH].vld && ctl_reg[PIPE_DEPTH].eval;
    assign last_load = ctl_reg[PIPE_DEPTH].vld && !ctl_reg[PIPE_DEPTH].eval;

    // hold everything only when a finished result blocks the last stage
    assign en       = !(ctl_reg[PIPE_DEPTH].vld && ctl_reg[PIPE_DEPTH].eval &&
                        out_vld_reg && !m_tready);
    assign s_tready = en;

    // control word pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                ctl_reg[k].vld <= 1'b0;
            end
        end else if (en) begin
            ctl_reg[1].vld  <= s_tvalid;
            ctl_reg[1].eval <= s_tuser[0];
            ctl_reg[1].idx  <= s_tdata[7:0];
            ctl_reg[1].val  <= s_tdata[16:8];
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // table writes, aligned with the read stage of each table
    assign perm_wr = '{wr: ctl_reg[PERM_POS].vld && !ctl_reg[PERM_POS].eval,
                       idx: ctl_reg[PERM_POS].idx, val: ctl_reg[PERM_POS].val};
    assign grad_wr = '{wr: ctl_reg[GRAD_POS].vld && !ctl_reg[GRAD_POS].eval,
                       idx: ctl_reg[GRAD_POS].idx, val: ctl_reg[GRAD_POS].val};

    snx_geom #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TB(TB)) u_geom (
        .aclk    (aclk),
        .en      (en),
        .x_coord (s_tdata[48:17]),
        .y_coord (s_tdata[80:49]),
        .ii      (ii),
        .jj      (jj),
        .step    (step),
        .dx      (dx),
        .dy      (dy)
    );

    snx_hash #(.TB(TB)) u_hash (
        .aclk    (aclk),
        .en      (en),
        .perm_wr (perm_wr),
        .grad_wr (grad_wr),
        .ii      (ii),
        .jj      (jj),
        .step    (step),
        .g       (g)
    );

    for (genvar c = 0; c < 3; c++) begin : g_corner
        snx_corner #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_corner (
            .aclk (aclk),
            .en   (en),
            .dx   (dx[c]),
            .dy   (dy[c]),
            .g    (g[c]),
            .term (term[c])
        );
    end

    // scale by 70, round half up, saturate
    always_comb begin
        scaled = (SCW'(sum_reg) * SCW'(NOISE_SCALE) + ROUND_HALF) >>> 15;
        priority if (scaled > SAT_HI) begin
            noise_next = NOISE_W'(SAT_HI);
        end else if (scaled < SAT_LO) begin
            noise_next = NOISE_W'(SAT_LO);
        end else begin
            noise_next = NOISE_W'(scaled);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= SUMW'(term[0]) + SUMW'(term[1]) + SUMW'(term[2]);
            noise_reg <= noise_next;
        end
    end

    // output register: drop loads, hold a result until taken
    always_comb begin
        out_vld_next = out_vld_reg && !m_tready;
        if (en && ctl_reg[PIPE_DEPTH].vld && ctl_reg[PIPE_DEPTH].eval) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && ctl_reg[PIPE_DEPTH].vld && ctl_reg[PIPE_DEPTH].eval) begin
            out_noise_reg <= noise_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_noise_reg;

    `SNX_ASSERT_IMPL(a_stall_cause, !en, out_vld_reg && !m_tready, "pipe held, no blocked result")
    `SNX_ASSERT_NEXT(a_eval_lands, last_eval && !out_vld_reg, out_vld_reg, "result lost at output")
    `SNX_ASSERT_NEXT(a_load_silent, last_load && !out_vld_reg, !out_vld_reg, "load gave a result")

endmodule

>>> verif/simplex_noise_2d_tb.sv
// Testbench for simplex_noise_2d: random stream traffic checked against a noise predictor
`timescale 1ns / 1ps
module simplex_noise_2d_tb import snx_pkg::*;;

    localparam int  TBL_N      = 256;
    localparam int  FRAC       = 16;
    localparam int  CYCLE_CAP  = 400000;
    localparam bit  CMD_LOAD   = 1'b0;
    localparam bit  CMD_EVAL   = 1'b1;
    localparam longint UNIT    = longint'(1) << FRAC;
    localparam longint G2_ONE  = UNSKEW_Q32 >>> (32 - FRAC);
    localparam longint G2_TWO  = (UNSKEW_Q32 * 2) >>> (32 - FRAC);

    // gradient vectors, x and y parts only
    localparam int GX [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
    localparam int GY [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // table_index[7:0], table_value[16:8], x_coord[48:17],
                            // y_coord[80:49], zero pad[87:81]
    logic [0:0]  s_tuser;   // cmd[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // noise_value[15:0]

    // predictor copy of the tables
    logic [8:0] perm_copy [TBL_N];
    logic [3:0] grad_copy [TBL_N];

    logic signed [15:0] noise_due [$];
    int  err_cnt = 0;
    int  cyc_cnt = 0;
    bit  quiet;
    int  sink_hold;

    simplex_noise_2d i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // falloff times gradient dot product for one corner, Q.30
    function automatic longint corner_q30(longint dx, longint dy, logic [3:0] g);
        longint base, u, u2, u4, d;
        base = (longint'(1) << (2 * FRAC - 1)) - dx * dx - dy * dy;
        if (base < 0) return 0;
        u  = base >>> (2 * FRAC - 30);
        u2 = (u * u) >>> 30;
        u4 = (u2 * u2) >>> 30;
        d  = GX[g] * dx + GY[g] * dy;
        return (u4 * (d <<< (30 - FRAC))) >>> 30;
    endfunction

    // noise at one Q16.16 point using the current table copy
    function automatic logic signed [15:0] noise_at(logic signed [31:0] xc,
                                                    logic signed [31:0] yc);
        longint x, y, s, i, j, t, x0, y0, sum, r;
        int si, sj;
        logic [7:0] ii, jj;
        logic [3:0] g0, g1, g2;
        x  = xc;
        y  = yc;
        s  = ((x + y) * SKEW_Q32) >>> 32;
        i  = (x + s) >>> FRAC;
        j  = (y + s) >>> FRAC;
        t  = ((i + j) * UNSKEW_Q32) >>> (32 - FRAC);
        x0 = x - i * UNIT + t;
        y0 = y - j * UNIT + t;
        // diagonal tie steps in y
        si = (x0 > y0) ? 1 : 0;
        sj = 1 - si;
        ii = i[7:0];
        jj = j[7:0];
        g0 = grad_copy[8'(ii + perm_copy[jj])];
        g1 = grad_copy[8'(ii + si + perm_copy[8'(jj + sj)])];
        g2 = grad_copy[8'(ii + 1 + perm_copy[8'(jj + 1)])];
        sum = corner_q30(x0, y0, g0)
            + corner_q30(x0 - si * UNIT + G2_ONE, y0 - sj * UNIT + G2_ONE, g1)
            + corner_q30(x0 - UNIT + G2_TWO, y0 - UNIT + G2_TWO, g2);
        r = (sum * NOISE_SCALE + (longint'(1) << 14)) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // send one request, with an optional idle burst before it
    task automatic send_req(bit cmd, logic [7:0] idx, logic [8:0] val,
                            logic [31:0] xc, logic [31:0] yc);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, yc, xc, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_LOAD) begin
            perm_copy[idx] = val;
            grad_copy[idx] = 4'(val % 12);
        end else begin
            noise_due.push_back(noise_at(xc, yc));
        end
    endtask

    task automatic send_load(logic [7:0] idx, logic [8:0] val);
        send_req(CMD_LOAD, idx, val, $urandom, $urandom);
    endtask

    task automatic send_eval(logic [31:0] xc, logic [31:0] yc);
        send_req(CMD_EVAL, 8'($urandom), 9'($urandom), xc, yc);
    endtask

    // write every permutation entry so no read hits an unwritten one
    task automatic test_table_fill();
        for (int k = 0; k < TBL_N; k++)
            send_load(8'(k), 9'($urandom_range(0, 256)));
    endtask

    // field extremes, out-of-range values, diagonal tie
    task automatic test_directed();
        send_load(8'd0, 9'd256);
        send_load(8'd255, 9'd511);
        send_load(8'd128, 9'd0);
        send_eval(32'h0000_0000, 32'h0000_0000);
        send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_eval(32'h8000_0000, 32'h8000_0000);
        send_eval(32'h7FFF_FFFF, 32'h8000_0000);
        send_eval(32'h8000_0000, 32'h7FFF_FFFF);
        send_eval(32'hFFFF_FFFF, 32'h0000_0001);
        send_eval(32'h0001_8000, 32'h0001_8000);
        send_eval(32'hFFFE_4000, 32'hFFFE_4000);
        send_eval(32'h0000_3000, 32'h0000_5000);
        send_eval(32'h0000_5000, 32'h0000_3000);
        send_eval(32'h00FF_0000, 32'hFF01_0000);
        send_load(8'd17, 9'd255);
        send_eval(32'h0010_8000, 32'h0011_2000);
    endtask

    // mostly near-origin points, some full range, with loads mixed in
    task automatic test_random_mix(int n);
        logic [31:0] xc, yc;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_load(8'($urandom), 9'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    xc = $urandom;
                    yc = $urandom;
                end else begin
                    xc = 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
                    yc = 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
                end
                send_eval(xc, yc);
            end
        end
    endtask

    // random result stalls in bursts
    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            m_tready <= 1'b1;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end else if ($urandom_range(0, 4) == 0) begin
            sink_hold <= $urandom_range(1, 4);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (noise_due.size() == 0) begin
                $error("noise_value: unexpected result %0d", $signed(m_tdata));
                err_cnt++;
            end else begin
                logic signed [15:0] want;
                want = noise_due.pop_front();
                if (want !== $signed(m_tdata)) begin
                    $error("noise_value expected %0d actual %0d", want, $signed(m_tdata));
                    err_cnt++;
                end
            end
        end
    end

    // stop a hung run
    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_CAP) begin
            $display("simplex_noise_2d_tb NOT OK");
            $finish;
        end
    end

    initial begin
        quiet    = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_fill();
        test_directed();
        test_random_mix(1300);
        quiet = 1'b1;
        test_random_mix(150);
        s_tvalid <= 1'b0;

        // drain the pipe
        while (noise_due.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (err_cnt == 0)
            $display("simplex_noise_2d_tb OK");
        else
            $display("simplex_noise_2d_tb NOT OK");
        $finish;
    end
endmodule
